// ===== sv/xkfs_pkg.sv =====
// Package for the single-byte XOR key search block.
// Holds the beat types, the cell control struct, the letter weight table and shared constants.
// No dependencies.
package xkfs_pkg;

  localparam int KEY_COUNT          = 256;
  localparam int KEY_BITS           = 8;
  localparam int WEIGHT_BITS        = 4;
  localparam int OUT_SCORE_BITS     = 16;
  localparam int SCORE_BITS_DEFAULT = 16;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_byte;
  } xkfs_in_t;

  typedef struct packed {
    logic [7:0]  best_key;
    logic [15:0] best_score;
  } xkfs_out_t;

  typedef struct packed {
    logic       add;
    logic       shift;
    logic [7:0] cipher_byte;
  } xkfs_cell_ctrl_t;

  typedef struct packed {
    logic first;
    logic step;
  } xkfs_max_ctrl_t;

  function automatic logic [WEIGHT_BITS-1:0] letter_weight(input logic [7:0] c);
    logic [WEIGHT_BITS-1:0] w;
    case (c)
      8'd101, 8'd69:          w = 4'd12;
      8'd116, 8'd84:          w = 4'd9;
      8'd97, 8'd65, 8'd111, 8'd79: w = 4'd8;
      8'd105, 8'd73, 8'd110, 8'd78, 8'd32: w = 4'd7;
      8'd115, 8'd83, 8'd104, 8'd72, 8'd114, 8'd82: w = 4'd6;
      8'd100, 8'd68, 8'd108, 8'd76: w = 4'd4;
      8'd117, 8'd85:          w = 4'd3;
      default:                w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/xkfs_cell.sv =====
// One key cell: holds the saturating score of a single XOR key.
// Depends on xkfs_pkg for the control struct and the letter weight table.
module xkfs_cell #(
  parameter int SCORE_BITS = xkfs_pkg::SCORE_BITS_DEFAULT,
  parameter logic [xkfs_pkg::KEY_BITS-1:0] KEY = '0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  xkfs_pkg::xkfs_cell_ctrl_t     ctrl,
  input  logic [SCORE_BITS-1:0]         shift_in,
  output logic [SCORE_BITS-1:0]         score
);

  logic [SCORE_BITS:0] sum;

  assign sum = {1'b0, score}
             + (SCORE_BITS+1)'(xkfs_pkg::letter_weight(ctrl.cipher_byte ^ KEY));

  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
    end else if (ctrl.shift) begin
      score <= shift_in;
    end else if (ctrl.add) begin
      score <= sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
    end
  end

endmodule

// ===== sv/xkfs_max.sv =====
// Running maximum over the scores that leave the end of the cell chain.
// Depends on xkfs_pkg for the control struct and key width.
module xkfs_max #(
  parameter int SCORE_BITS = xkfs_pkg::SCORE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  xkfs_pkg::xkfs_max_ctrl_t      ctrl,
  input  logic [xkfs_pkg::KEY_BITS-1:0] key,
  input  logic [SCORE_BITS-1:0]         score,
  output logic [xkfs_pkg::KEY_BITS-1:0] best_key,
  output logic [SCORE_BITS-1:0]         best_score
);

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      if (ctrl.first || (score > best_score)) begin
        best_key   <= key;
        best_score <= score;
      end
    end
  end

endmodule

// ===== sv/xor_key_frequency_search.sv =====
// Top level of the single-byte XOR key search block.
// Depends on xkfs_pkg, xkfs_cell and xkfs_max.
//
// Ciphertext arrives one byte per beat on the byte channel (byte_valid,
// byte_stall, byte_data); last_byte marks the final byte of a message.
// A row of 256 cells, one per key, adds the letter weight of byte XOR key
// to every score in the cycle the beat is accepted, so ordinary bytes go
// in at one per cycle.
// After the final byte the cell row turns into a shift register: the scores
// move one cell toward key 0 and leave the row into a single comparator,
// while zeros enter at the far end. That scan clears the scores and finds
// the best key, lowest key on ties.
// byte_stall is high during the scan and until the result is loaded into
// the output register. A result held by result_stall stays in the output
// register while new bytes of the next message are taken; only the next
// result then waits in the comparator, with byte_stall high, until the
// held beat is taken.
// Synchronous reset clears all scores and drops result_valid.
module xor_key_frequency_search #(
  parameter int SCORE_BITS = xkfs_pkg::SCORE_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  xkfs_pkg::xkfs_in_t  byte_data,
  output logic                result_valid,
  input  logic                result_stall,
  output xkfs_pkg::xkfs_out_t result_data
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;
  localparam int CNT_BITS = xkfs_pkg::KEY_BITS;
  localparam int WIDE_BITS = (SCORE_BITS > xkfs_pkg::OUT_SCORE_BITS) ?
                             SCORE_BITS : xkfs_pkg::OUT_SCORE_BITS;
  localparam logic [WIDE_BITS-1:0] OUT_MAX = WIDE_BITS'({xkfs_pkg::OUT_SCORE_BITS{1'b1}});

  logic [1:0]                    state;
  logic [CNT_BITS-1:0]           cnt;
  logic                          accept;
  logic                          result_load;
  xkfs_pkg::xkfs_cell_ctrl_t     cell_ctrl;
  xkfs_pkg::xkfs_max_ctrl_t      max_ctrl;
  logic [SCORE_BITS-1:0]         scores [xkfs_pkg::KEY_COUNT];
  logic [xkfs_pkg::KEY_BITS-1:0] best_key;
  logic [SCORE_BITS-1:0]         best_score;
  logic [WIDE_BITS-1:0]          wide_score;

  assign byte_stall  = (state != ST_RUN);
  assign accept      = byte_valid && !byte_stall;
  assign result_load = (state == ST_HOLD) && (!result_valid || !result_stall);

  assign cell_ctrl.add         = accept;
  assign cell_ctrl.shift       = (state == ST_SCAN);
  assign cell_ctrl.cipher_byte = byte_data.cipher_byte;

  assign max_ctrl.step  = (state == ST_SCAN);
  assign max_ctrl.first = (cnt == '0);

  for (genvar k = 0; k < xkfs_pkg::KEY_COUNT; k++) begin : g_cell
    logic [SCORE_BITS-1:0] shift_in;
    if (k == xkfs_pkg::KEY_COUNT - 1) begin : g_end
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = scores[k+1];
    end
    xkfs_cell #(
      .SCORE_BITS (SCORE_BITS),
      .KEY        (CNT_BITS'(k))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .shift_in (shift_in),
      .score    (scores[k])
    );
  end

  xkfs_max #(
    .SCORE_BITS (SCORE_BITS)
  ) u_max (
    .clk        (clk),
    .ctrl       (max_ctrl),
    .key        (cnt),
    .score      (scores[0]),
    .best_key   (best_key),
    .best_score (best_score)
  );

  assign wide_score = WIDE_BITS'(best_score);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (accept && byte_data.last_byte) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == {CNT_BITS{1'b1}}) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (result_load) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result_data.best_key   <= best_key;
      result_data.best_score <= (wide_score > OUT_MAX) ? 16'hFFFF :
                                wide_score[xkfs_pkg::OUT_SCORE_BITS-1:0];
    end
  end

  a_final_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_data.last_byte) |=> (state == ST_SCAN && cnt == '0))
    else $error("final byte did not start the score scan");

  a_scores_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |->
      (scores[0] == '0 && scores[xkfs_pkg::KEY_COUNT-1] == '0))
    else $error("scores not cleared after the scan");

  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_HOLD))
    else $error("result appeared without a finished scan");

  a_no_add_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !cell_ctrl.add)
    else $error("byte accepted during the scan");

endmodule

// ===== sim/xor_key_frequency_search_tb.sv =====
// Testbench for xor_key_frequency_search: drives messages of ciphertext bytes, predicts
// the best single-byte XOR key per message and checks every result beat.
// Depends on xkfs_pkg and the xor_key_frequency_search RTL.
`timescale 1ns / 100ps

module xor_key_frequency_search_tb;

  localparam int unsigned SCORE_LIMIT = 65535;
  localparam string PROSE =
    "It was the best of times, it WAS the Worst of times; several HUNDRED riders ran Under the old Lamp.";

  class key_score_board;
    int unsigned key_score[xkfs_pkg::KEY_COUNT];
    int unsigned char_weight[xkfs_pkg::KEY_COUNT];
    xkfs_pkg::xkfs_out_t best_key_q[$];
    int errors;
    int bytes_seen;
    int results_seen;

    function new();
      string letters;
      int unsigned weights[25];
      letters = "eEtTaAoOiInN sShHrRdDlLuU";
      weights = '{12, 12, 9, 9, 8, 8, 8, 8, 7, 7, 7, 7, 7, 6, 6, 6, 6, 6, 6, 4, 4, 4, 4, 3, 3};
      foreach (char_weight[c]) char_weight[c] = 0;
      foreach (weights[i]) char_weight[letters[i]] = weights[i];
      foreach (key_score[k]) key_score[k] = 0;
      errors = 0;
      bytes_seen = 0;
      results_seen = 0;
    endfunction

    function void note_byte(xkfs_pkg::xkfs_in_t beat);
      int unsigned sum;
      xkfs_pkg::xkfs_out_t best;
      bytes_seen++;
      for (int k = 0; k < xkfs_pkg::KEY_COUNT; k++) begin
        sum = key_score[k] + char_weight[beat.cipher_byte ^ 8'(k)];
        key_score[k] = (sum > SCORE_LIMIT) ? SCORE_LIMIT : sum;
      end
      if (beat.last_byte) begin
        best.best_key = 8'd0;
        best.best_score = 16'(key_score[0]);
        for (int k = 1; k < xkfs_pkg::KEY_COUNT; k++) begin
          if (key_score[k] > best.best_score) begin
            best.best_key = 8'(k);
            best.best_score = 16'(key_score[k]);
          end
        end
        best_key_q.insert(best_key_q.size(), best);
        foreach (key_score[k]) key_score[k] = 0;
      end
    endfunction

    function void check_result(xkfs_pkg::xkfs_out_t got);
      xkfs_pkg::xkfs_out_t want;
      results_seen++;
      if (best_key_q.size() == 0) begin
        $display("%0t: unexpected result beat key=%0d score=%0d", $time, got.best_key,
                 got.best_score);
        errors++;
        return;
      end
      want = best_key_q.pop_front();
      if (got.best_key !== want.best_key) begin
        $display("%0t: best_key expected %0d actual %0d", $time, want.best_key, got.best_key);
        errors++;
      end
      if (got.best_score !== want.best_score) begin
        $display("%0t: best_score expected %0d actual %0d", $time, want.best_score,
                 got.best_score);
        errors++;
      end
    endfunction

    function int pending();
      return best_key_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                byte_valid;
  logic                byte_stall;
  xkfs_pkg::xkfs_in_t  byte_data;
  logic                result_valid;
  logic                result_stall;
  xkfs_pkg::xkfs_out_t result_data;

  key_score_board sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int bytes_sent = 0;
  int messages_sent = 0;

  xor_key_frequency_search u_top (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data(byte_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) sb.note_byte(byte_data);
      if (result_valid && !result_stall) sb.check_result(result_data);
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= '{cipher_byte: value, last_byte: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (last) messages_sent++;
  endtask

  task automatic send_text(input int len, input logic [7:0] key);
    int start;
    start = $urandom_range(PROSE.len() - 1);
    for (int i = 0; i < len; i++)
      send_byte(8'(PROSE[(start + i) % PROSE.len()]) ^ key, i == len - 1);
  endtask

  task automatic send_noise(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int sender_gap, input int receiver_gap, input int count);
    int target;
    int pick;
    send_idle = sender_gap;
    recv_idle = receiver_gap;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) send_text($urandom_range(1, 24), 8'($urandom_range(255)));
      else if (pick < 90) send_noise($urandom_range(1, 16));
      else send_byte(8'($urandom_range(255)), 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h20, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_text(6, 8'h00);
    send_text(6, 8'hFF);
    send_text(4, 8'h5A);
    wait_drained();

    run_phase(25, 84, 190);
    run_phase(84, 25, 190);
    run_phase(0, 0, 190);

    repeat (300) @(posedge clk);
    $display("Sent %0d bytes in %0d messages of text, noise and single final bytes;",
             bytes_sent, messages_sent);
    $display("checked %0d result beats under three sender and receiver stall mixes.",
             sb.results_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
